[design/kc_pkg.sv]
// Shared types, constants and arithmetic helpers for the keypad calculator core.
// Used by kc_datapath, kc_ctrl and keypad_calculator_core; depends on nothing.
`timescale 1ns / 1ps

package kc_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int FRACTION_BITS = 32;
    localparam int VAL_W         = 64;
    localparam int PAIR_W        = 2 * VAL_W;
    localparam int HIST_AW       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HIST_CW       = $clog2(HISTORY_DEPTH + 1);
    localparam int IN_DATA_W     = 8;
    localparam int OUT_DATA_W    = 144;
    localparam int MUL_STEPS     = VAL_W;
    localparam int DIV_STEPS     = PAIR_W;
    localparam int CNT_W         = 8;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Command key codes.
    localparam logic [4:0] KEY_NOP       = 5'd0;
    localparam logic [4:0] KEY_NOT       = 5'd8;
    localparam logic [4:0] KEY_CLR_ENTRY = 5'd9;
    localparam logic [4:0] KEY_CLR_ALL   = 5'd10;
    localparam logic [4:0] KEY_UNDO      = 5'd11;
    localparam logic [4:0] KEY_REDO      = 5'd12;
    localparam logic [4:0] KEY_RADIX     = 5'd13;
    // Number key codes.
    localparam logic [4:0] KEY_DIGIT_MAX = 5'd15;
    localparam logic [4:0] KEY_POINT     = 5'd16;

    // Pending operator codes.
    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_DIV  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_OR   = 4'd6;
    localparam logic [3:0] OP_XOR  = 4'd7;
    localparam logic [3:0] OP_NOT  = 4'd8;

    localparam logic [3:0] POINT_MAX = 4'd15;

    localparam logic [VAL_W-1:0] DEC_POW [16] = '{
        64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
        64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
        64'd100000000000, 64'd1000000000000, 64'd10000000000000,
        64'd100000000000000, 64'd1000000000000000
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCALE,
        ST_ADD_DIGIT,
        ST_FRAC_START,
        ST_DIV_RUN,
        ST_ADD_FRAC,
        ST_DIV_DONE,
        ST_MUL_RUN,
        ST_MUL_DONE,
        ST_POP_LOAD,
        ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_SET_POINT,
        DP_BUMP_POINT,
        DP_SCALE,
        DP_ADD_DIGIT,
        DP_FRAC_START,
        DP_QDIV_START,
        DP_DIV_STEP,
        DP_ADD_FRAC,
        DP_QDIV_DONE,
        DP_MUL_START,
        DP_MUL_STEP,
        DP_MUL_DONE,
        DP_ALU,
        DP_SET_PENDING,
        DP_CLR_ENTRY,
        DP_CLR_ALL,
        DP_TOGGLE,
        DP_LOAD_POP
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic       push_undo;
        logic       push_redo;
        logic       pop_undo;
        logic       pop_redo;
        logic       emit;
        logic       full;
        logic [3:0] shown;
        logic [4:0] code;
    } t_dp_cmd;

    typedef struct packed {
        logic       point_nz;
        logic [3:0] pending;
        logic       iter_last;
        logic       out_free;
    } t_dp_sts;

    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
        return s[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_sub(
        input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
        return s[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] mag(input logic signed [VAL_W-1:0] v);
        return v[VAL_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic signed [VAL_W-1:0] from_mag(
        input logic neg, input logic [VAL_W-1:0] m);
        if (!neg) return m[VAL_W-1] ? VAL_MAX : m;
        if (m[VAL_W-1]) return VAL_MIN;
        return ~m + 1'b1;
    endfunction

    // Low 32 bits of the integer part, truncated toward zero.
    function automatic logic [31:0] int_part(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] t;
        logic                    frac_nz;
        t       = v >>> FRACTION_BITS;
        frac_nz = |v[FRACTION_BITS-1:0];
        return t[31:0] + {31'd0, v[VAL_W-1] & frac_nz};
    endfunction

    function automatic logic signed [VAL_W-1:0] from_int32(input logic [31:0] w);
        logic signed [VAL_W+31:0] x;
        x = $signed({{VAL_W{w[31]}}, w}) <<< FRACTION_BITS;
        if ((&x[VAL_W+31:VAL_W-1]) || !(|x[VAL_W+31:VAL_W-1])) return x[VAL_W-1:0];
        return x[VAL_W+31] ? VAL_MIN : VAL_MAX;
    endfunction

    function automatic logic [VAL_W-1:0] radix_pow(input logic hex, input logic [3:0] k);
        return hex ? (64'd1 << {k, 2'b00}) : DEC_POW[k];
    endfunction

endpackage

[design/kc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the undo and redo history stores; no dependencies.
`timescale 1ns / 1ps

module kc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/kc_datapath.sv]
// Calculator datapath: value registers, shift-add multiplier, restoring divider,
// history stacks and the result register. Depends on kc_pkg and kc_ram.
`timescale 1ns / 1ps

module kc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kc_pkg::t_dp_cmd               i_cmd,
    output kc_pkg::t_dp_sts               o_sts,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [kc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tuser
);

    localparam int SW = kc_pkg::HIST_CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(kc_pkg::HISTORY_DEPTH);
    localparam int VW = kc_pkg::VAL_W;
    localparam int PW = kc_pkg::PAIR_W;

    logic signed [VW-1:0] r_acc, n_acc, r_entry, n_entry;
    logic [3:0]           r_point, n_point, r_pending, n_pending;
    logic                 r_hex, n_hex;
    logic [PW-1:0]        r_num, n_num;
    logic [VW:0]          r_rem, n_rem;
    logic [VW-1:0]        r_dsr, n_dsr;
    logic                 r_neg, n_neg, r_dzero, n_dzero;
    logic [kc_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_pop_hit, n_pop_hit, r_pop_sel, n_pop_sel;

    logic [kc_pkg::HIST_AW-1:0] r_ubase, n_ubase, r_rbase, n_rbase;
    logic [kc_pkg::HIST_CW-1:0] r_ucnt, n_ucnt, r_rcnt, n_rcnt;

    logic                 r_out_valid, n_out_valid;
    logic                 r_out_full;
    logic signed [VW-1:0] r_out_acc, r_out_entry;
    logic                 r_out_hex;
    logic [3:0]           r_out_point, r_out_shown;

    logic [kc_pkg::HIST_AW-1:0] u_waddr, u_raddr, rd_waddr, rd_raddr;
    logic [PW-1:0]        u_rdata, d_rdata, pair_wdata, pop_data;
    logic [SW-1:0]        us_w, us_r, rs_w, rs_r;

    logic signed [VW+3:0] scale_x, scale_p;
    logic [VW:0]          mul_sum, div_sh;
    logic                 div_ge;
    logic [PW-1:0]        prod, prod_sh;
    logic [31:0]          ia, ie;
    logic signed [VW-1:0] alu_res, digit_val;
    logic                 out_free;

    // Stack slot addresses: next free slot and top of stack, modulo the depth.
    always_comb begin
        us_w = SW'(r_ubase) + SW'(r_ucnt);
        if (us_w >= DEPTH_S) us_w = us_w - DEPTH_S;
        us_r = SW'(r_ubase) + SW'(r_ucnt) + DEPTH_S - SW'(1);
        if (us_r >= DEPTH_S) us_r = us_r - DEPTH_S;
        if (us_r >= DEPTH_S) us_r = us_r - DEPTH_S;
        rs_w = SW'(r_rbase) + SW'(r_rcnt);
        if (rs_w >= DEPTH_S) rs_w = rs_w - DEPTH_S;
        rs_r = SW'(r_rbase) + SW'(r_rcnt) + DEPTH_S - SW'(1);
        if (rs_r >= DEPTH_S) rs_r = rs_r - DEPTH_S;
        if (rs_r >= DEPTH_S) rs_r = rs_r - DEPTH_S;
    end

    assign u_waddr    = us_w[kc_pkg::HIST_AW-1:0];
    assign u_raddr    = us_r[kc_pkg::HIST_AW-1:0];
    assign rd_waddr   = rs_w[kc_pkg::HIST_AW-1:0];
    assign rd_raddr   = rs_r[kc_pkg::HIST_AW-1:0];
    assign pair_wdata = {r_entry, r_acc};

    kc_ram #(.WIDTH(PW), .DEPTH(kc_pkg::HISTORY_DEPTH)) u_undo_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_undo),
        .i_waddr (u_waddr),
        .i_wdata (pair_wdata),
        .i_raddr (u_raddr),
        .o_rdata (u_rdata)
    );

    kc_ram #(.WIDTH(PW), .DEPTH(kc_pkg::HISTORY_DEPTH)) u_redo_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_redo),
        .i_waddr (rd_waddr),
        .i_wdata (pair_wdata),
        .i_raddr (rd_raddr),
        .o_rdata (d_rdata)
    );

    // Arithmetic shared by the datapath operations.
    always_comb begin
        scale_x   = {{4{r_entry[VW-1]}}, r_entry};
        scale_p   = r_hex ? (scale_x <<< 4) : ((scale_x <<< 3) + (scale_x <<< 1));
        mul_sum   = r_num[0] ? ({1'b0, r_rem[VW-1:0]} + {1'b0, r_dsr})
                             : {1'b0, r_rem[VW-1:0]};
        div_sh    = {r_rem[VW-1:0], r_num[PW-1]};
        div_ge    = div_sh >= {1'b0, r_dsr};
        prod      = {r_rem[VW-1:0], r_num[VW-1:0]};
        prod_sh   = prod >> kc_pkg::FRACTION_BITS;
        ia        = kc_pkg::int_part(r_acc);
        ie        = kc_pkg::int_part(r_entry);
        digit_val = VW'({i_cmd.code[3:0]}) << kc_pkg::FRACTION_BITS;
        pop_data  = r_pop_sel ? d_rdata : u_rdata;
        case (r_pending)
            kc_pkg::OP_ADD: alu_res = kc_pkg::sat_add(r_acc, r_entry);
            kc_pkg::OP_SUB: alu_res = kc_pkg::sat_sub(r_acc, r_entry);
            kc_pkg::OP_AND: alu_res = kc_pkg::from_int32(ia & ie);
            kc_pkg::OP_OR:  alu_res = kc_pkg::from_int32(ia | ie);
            kc_pkg::OP_XOR: alu_res = kc_pkg::from_int32(ia ^ ie);
            kc_pkg::OP_NOT: alu_res = kc_pkg::from_int32(~ia);
            default:        alu_res = r_acc;
        endcase
    end

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_acc     = r_acc;
        n_entry   = r_entry;
        n_point   = r_point;
        n_hex     = r_hex;
        n_pending = r_pending;
        n_num     = r_num;
        n_rem     = r_rem;
        n_dsr     = r_dsr;
        n_neg     = r_neg;
        n_dzero   = r_dzero;
        n_cnt     = r_cnt;
        n_pop_hit = r_pop_hit;
        n_pop_sel = r_pop_sel;
        n_ubase   = r_ubase;
        n_ucnt    = r_ucnt;
        n_rbase   = r_rbase;
        n_rcnt    = r_rcnt;

        // A push onto a full stack overwrites the oldest slot and moves the base.
        if (i_cmd.push_undo) begin
            if (SW'(r_ucnt) == DEPTH_S) begin
                n_ubase = (SW'(r_ubase) == DEPTH_S - SW'(1)) ? '0 : r_ubase + 1'b1;
            end else begin
                n_ucnt = r_ucnt + 1'b1;
            end
        end
        if (i_cmd.push_redo) begin
            if (SW'(r_rcnt) == DEPTH_S) begin
                n_rbase = (SW'(r_rbase) == DEPTH_S - SW'(1)) ? '0 : r_rbase + 1'b1;
            end else begin
                n_rcnt = r_rcnt + 1'b1;
            end
        end
        if (i_cmd.pop_undo) begin
            n_pop_hit = r_ucnt != '0;
            n_pop_sel = 1'b0;
            if (r_ucnt != '0) n_ucnt = r_ucnt - 1'b1;
        end
        if (i_cmd.pop_redo) begin
            n_pop_hit = r_rcnt != '0;
            n_pop_sel = 1'b1;
            if (r_rcnt != '0) n_rcnt = r_rcnt - 1'b1;
        end

        case (i_cmd.op)
            kc_pkg::DP_SET_POINT: begin
                if (r_point == 4'd0) n_point = 4'd1;
            end
            kc_pkg::DP_BUMP_POINT: begin
                if (r_point != 4'd0 && r_point != kc_pkg::POINT_MAX) n_point = r_point + 4'd1;
            end
            kc_pkg::DP_SCALE: begin
                if ((&scale_p[VW+3:VW-1]) || !(|scale_p[VW+3:VW-1])) begin
                    n_entry = scale_p[VW-1:0];
                end else begin
                    n_entry = scale_p[VW+3] ? kc_pkg::VAL_MIN : kc_pkg::VAL_MAX;
                end
            end
            kc_pkg::DP_ADD_DIGIT: n_entry = kc_pkg::sat_add(r_entry, digit_val);
            kc_pkg::DP_FRAC_START: begin
                n_num = PW'(digit_val);
                n_dsr = kc_pkg::radix_pow(r_hex, r_point - 4'd1);
                n_rem = '0;
                n_cnt = kc_pkg::CNT_W'(kc_pkg::DIV_STEPS);
            end
            kc_pkg::DP_QDIV_START: begin
                n_num   = PW'(kc_pkg::mag(r_acc)) << kc_pkg::FRACTION_BITS;
                n_dsr   = kc_pkg::mag(r_entry);
                n_neg   = r_acc[VW-1] ^ r_entry[VW-1];
                n_dzero = r_entry == '0;
                n_rem   = '0;
                n_cnt   = kc_pkg::CNT_W'(kc_pkg::DIV_STEPS);
            end
            kc_pkg::DP_DIV_STEP: begin
                n_rem = div_ge ? (div_sh - {1'b0, r_dsr}) : div_sh;
                n_num = {r_num[PW-2:0], div_ge};
                n_cnt = r_cnt - 1'b1;
            end
            kc_pkg::DP_ADD_FRAC: n_entry = kc_pkg::sat_add(r_entry, r_num[VW-1:0]);
            kc_pkg::DP_QDIV_DONE: begin
                if (r_dzero) begin
                    n_acc = '0;
                end else begin
                    n_acc = kc_pkg::from_mag(r_neg,
                        (|r_num[PW-1:VW]) ? {VW{1'b1}} : r_num[VW-1:0]);
                end
                n_entry   = '0;
                n_point   = 4'd0;
                n_pending = i_cmd.code[3:0];
            end
            kc_pkg::DP_MUL_START: begin
                n_dsr = kc_pkg::mag(r_acc);
                n_num = PW'(kc_pkg::mag(r_entry));
                n_neg = r_acc[VW-1] ^ r_entry[VW-1];
                n_rem = '0;
                n_cnt = kc_pkg::CNT_W'(kc_pkg::MUL_STEPS);
            end
            kc_pkg::DP_MUL_STEP: begin
                n_rem = {1'b0, mul_sum[VW:1]};
                n_num = {r_num[PW-1:VW], mul_sum[0], r_num[VW-1:1]};
                n_cnt = r_cnt - 1'b1;
            end
            kc_pkg::DP_MUL_DONE: begin
                n_acc = kc_pkg::from_mag(r_neg,
                    (|prod_sh[PW-1:VW]) ? {VW{1'b1}} : prod_sh[VW-1:0]);
                n_entry   = '0;
                n_point   = 4'd0;
                n_pending = i_cmd.code[3:0];
            end
            kc_pkg::DP_ALU: begin
                n_acc     = alu_res;
                n_entry   = '0;
                n_point   = 4'd0;
                n_pending = i_cmd.code[3:0];
            end
            kc_pkg::DP_SET_PENDING: n_pending = i_cmd.code[3:0];
            kc_pkg::DP_CLR_ENTRY: begin
                n_entry = '0;
                n_point = 4'd0;
            end
            kc_pkg::DP_CLR_ALL: begin
                n_acc     = '0;
                n_entry   = '0;
                n_point   = 4'd0;
                n_hex     = 1'b0;
                n_pending = kc_pkg::OP_ADD;
            end
            kc_pkg::DP_TOGGLE: n_hex = ~r_hex;
            kc_pkg::DP_LOAD_POP: begin
                if (r_pop_hit) begin
                    n_acc   = pop_data[VW-1:0];
                    n_entry = pop_data[PW-1:VW];
                end
            end
            default: ;
        endcase

        n_out_valid = r_out_valid;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_entry     <= '0;
            r_point     <= '0;
            r_hex       <= 1'b0;
            r_pending   <= kc_pkg::OP_ADD;
            r_cnt       <= '0;
            r_pop_hit   <= 1'b0;
            r_pop_sel   <= 1'b0;
            r_ubase     <= '0;
            r_ucnt      <= '0;
            r_rbase     <= '0;
            r_rcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_entry     <= n_entry;
            r_point     <= n_point;
            r_hex       <= n_hex;
            r_pending   <= n_pending;
            r_cnt       <= n_cnt;
            r_pop_hit   <= n_pop_hit;
            r_pop_sel   <= n_pop_sel;
            r_ubase     <= n_ubase;
            r_ucnt      <= n_ucnt;
            r_rbase     <= n_rbase;
            r_rcnt      <= n_rcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_dsr   <= n_dsr;
        r_neg   <= n_neg;
        r_dzero <= n_dzero;
        if (i_cmd.emit) begin
            r_out_full  <= i_cmd.full;
            r_out_acc   <= i_cmd.full ? r_acc : '0;
            r_out_entry <= r_entry;
            r_out_hex   <= i_cmd.full & r_hex;
            r_out_point <= r_point;
            r_out_shown <= i_cmd.shown;
        end
    end

    assign o_sts.point_nz  = r_point != 4'd0;
    assign o_sts.pending   = r_pending;
    assign o_sts.iter_last = r_cnt == kc_pkg::CNT_W'(1);
    assign o_sts.out_free  = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_full;
    assign o_m_tdata  = {7'd0, r_out_shown, r_out_point, r_out_hex, r_out_entry, r_out_acc};

endmodule

[design/kc_ctrl.sv]
// Controller state machine: accepts keys, sequences datapath operations and
// hands finished results to the output register. Depends on kc_pkg.
`timescale 1ns / 1ps

module kc_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [kc_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic                         i_s_tuser,
    input  kc_pkg::t_dp_sts              i_sts,
    output kc_pkg::t_dp_cmd              o_cmd
);

    kc_pkg::t_state r_state, n_state;
    logic           r_cmd;
    logic [4:0]     r_code;
    logic           accept;

    assign o_s_tready = r_state == kc_pkg::ST_IDLE;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_s_tuser;
            r_code <= i_s_tdata[4:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kc_pkg::ST_IDLE: begin
                if (accept) n_state = kc_pkg::ST_DECODE;
            end
            kc_pkg::ST_DECODE: begin
                if (!r_cmd) begin
                    if (r_code > kc_pkg::KEY_POINT) begin
                        n_state = kc_pkg::ST_IDLE;
                    end else if (r_code == kc_pkg::KEY_POINT) begin
                        n_state = i_sts.point_nz ? kc_pkg::ST_IDLE : kc_pkg::ST_EMIT;
                    end else begin
                        n_state = i_sts.point_nz ? kc_pkg::ST_FRAC_START : kc_pkg::ST_SCALE;
                    end
                end else begin
                    case (r_code) inside
                        [kc_pkg::KEY_NOP:kc_pkg::KEY_NOT]: begin
                            if (i_sts.pending == kc_pkg::OP_MUL) begin
                                n_state = kc_pkg::ST_MUL_RUN;
                            end else if (i_sts.pending == kc_pkg::OP_DIV) begin
                                n_state = kc_pkg::ST_DIV_RUN;
                            end else begin
                                n_state = kc_pkg::ST_EMIT;
                            end
                        end
                        kc_pkg::KEY_CLR_ENTRY, kc_pkg::KEY_CLR_ALL, kc_pkg::KEY_RADIX:
                            n_state = kc_pkg::ST_EMIT;
                        kc_pkg::KEY_UNDO, kc_pkg::KEY_REDO:
                            n_state = kc_pkg::ST_POP_LOAD;
                        default: n_state = kc_pkg::ST_IDLE;
                    endcase
                end
            end
            kc_pkg::ST_SCALE:      n_state = kc_pkg::ST_ADD_DIGIT;
            kc_pkg::ST_ADD_DIGIT:  n_state = kc_pkg::ST_EMIT;
            kc_pkg::ST_FRAC_START: n_state = kc_pkg::ST_DIV_RUN;
            kc_pkg::ST_DIV_RUN: begin
                if (i_sts.iter_last) begin
                    n_state = r_cmd ? kc_pkg::ST_DIV_DONE : kc_pkg::ST_ADD_FRAC;
                end
            end
            kc_pkg::ST_ADD_FRAC:   n_state = kc_pkg::ST_EMIT;
            kc_pkg::ST_DIV_DONE:   n_state = kc_pkg::ST_EMIT;
            kc_pkg::ST_MUL_RUN: begin
                if (i_sts.iter_last) n_state = kc_pkg::ST_MUL_DONE;
            end
            kc_pkg::ST_MUL_DONE:   n_state = kc_pkg::ST_EMIT;
            kc_pkg::ST_POP_LOAD:   n_state = kc_pkg::ST_EMIT;
            kc_pkg::ST_EMIT: begin
                if (i_sts.out_free) n_state = kc_pkg::ST_IDLE;
            end
            default: n_state = kc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = kc_pkg::DP_NONE;
        o_cmd.code      = r_code;
        o_cmd.full      = r_cmd;
        o_cmd.shown     = (r_cmd && r_code <= kc_pkg::KEY_NOT) ? r_code[3:0] : 4'd0;
        unique case (r_state)
            kc_pkg::ST_DECODE: begin
                if (!r_cmd) begin
                    if (r_code == kc_pkg::KEY_POINT) begin
                        o_cmd.push_undo = 1'b1;
                        o_cmd.op        = kc_pkg::DP_SET_POINT;
                    end else if (r_code <= kc_pkg::KEY_DIGIT_MAX) begin
                        o_cmd.push_undo = 1'b1;
                        o_cmd.op        = kc_pkg::DP_BUMP_POINT;
                    end
                end else begin
                    case (r_code) inside
                        [kc_pkg::KEY_NOP:kc_pkg::KEY_NOT]: begin
                            o_cmd.push_undo = 1'b1;
                            if (i_sts.pending == kc_pkg::OP_NONE) begin
                                o_cmd.op = kc_pkg::DP_SET_PENDING;
                            end else if (i_sts.pending == kc_pkg::OP_MUL) begin
                                o_cmd.op = kc_pkg::DP_MUL_START;
                            end else if (i_sts.pending == kc_pkg::OP_DIV) begin
                                o_cmd.op = kc_pkg::DP_QDIV_START;
                            end else begin
                                o_cmd.op = kc_pkg::DP_ALU;
                            end
                        end
                        kc_pkg::KEY_CLR_ENTRY: o_cmd.op = kc_pkg::DP_CLR_ENTRY;
                        kc_pkg::KEY_CLR_ALL:   o_cmd.op = kc_pkg::DP_CLR_ALL;
                        kc_pkg::KEY_UNDO: begin
                            o_cmd.push_redo = 1'b1;
                            o_cmd.pop_undo  = 1'b1;
                        end
                        kc_pkg::KEY_REDO: begin
                            o_cmd.push_undo = 1'b1;
                            o_cmd.pop_redo  = 1'b1;
                        end
                        kc_pkg::KEY_RADIX:     o_cmd.op = kc_pkg::DP_TOGGLE;
                        default: ;
                    endcase
                end
            end
            kc_pkg::ST_SCALE:      o_cmd.op = kc_pkg::DP_SCALE;
            kc_pkg::ST_ADD_DIGIT:  o_cmd.op = kc_pkg::DP_ADD_DIGIT;
            kc_pkg::ST_FRAC_START: o_cmd.op = kc_pkg::DP_FRAC_START;
            kc_pkg::ST_DIV_RUN:    o_cmd.op = kc_pkg::DP_DIV_STEP;
            kc_pkg::ST_ADD_FRAC:   o_cmd.op = kc_pkg::DP_ADD_FRAC;
            kc_pkg::ST_DIV_DONE:   o_cmd.op = kc_pkg::DP_QDIV_DONE;
            kc_pkg::ST_MUL_RUN:    o_cmd.op = kc_pkg::DP_MUL_STEP;
            kc_pkg::ST_MUL_DONE:   o_cmd.op = kc_pkg::DP_MUL_DONE;
            kc_pkg::ST_POP_LOAD:   o_cmd.op = kc_pkg::DP_LOAD_POP;
            kc_pkg::ST_EMIT:       o_cmd.emit = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

[design/keypad_calculator_core.sv]
// Keypad calculator core, one key per request. A pending multiply runs on a 64-step shift-add
// multiplier; a pending divide and fraction digits run on a 128-step restoring divider.
// Integer digits scale the entry and then add the digit; undo and redo load the popped pair.
// One key is in flight at a time; a new key is taken only once the result is registered.
// Reset (i_rst_n low, synchronous) clears values and mode, sets add pending, empties the stacks.
`timescale 1ns / 1ps

module keypad_calculator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [kc_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [4:0] key_code
    input  logic                          i_s_tuser,   // [0] cmd
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [63:0] acc_value, [127:64] entry_value, [128] hex_shown,
    // [132:129] point_shown, [136:133] shown_operator
    output logic [kc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tuser    // [0] full_update
);

    kc_pkg::t_dp_cmd dp_cmd;
    kc_pkg::t_dp_sts dp_sts;

    kc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    kc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

[sim/keypad_calculator_core_tb.sv]
// Self-checking testbench for keypad_calculator_core: drives random and directed key requests,
// predicts every result in place and checks it field by field. Depends on kc_pkg and the core.
`timescale 1ns / 1ps

module keypad_calculator_core_tb;

    typedef struct packed {
        logic       cmd;
        logic [4:0] code;
    } t_key;

    typedef struct {
        logic              full;
        logic [63:0]       acc;
        logic [63:0]       ent;
        logic              hex;
        logic [3:0]        pnt;
        logic [3:0]        shown;
    } t_disp;

    localparam longint LIMIT = 3000000;
    localparam logic signed [63:0] S_MAX = 64'sh7fffffffffffffff;
    localparam logic signed [63:0] S_MIN = 64'sh8000000000000000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [7:0]   i_s_tdata = '0;
    logic         i_s_tuser = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [143:0] o_m_tdata;
    logic         o_m_tuser;

    keypad_calculator_core uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    logic signed [63:0] c_acc, c_ent;
    logic [3:0]         c_pnt, c_pend;
    logic               c_hex;
    logic [63:0]        u_acc [16], u_ent [16], r_acc [16], r_ent [16];
    int                 u_cnt, r_cnt;

    t_key  key_q [$];
    t_disp disp_q [$];
    bit    failed = 0;
    bit    calm = 0;
    logic  s_taken = 1'b0;
    longint cycles = 0;

    function automatic logic [63:0] mg(logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic signed [63:0] fm(bit neg, logic [63:0] m);
        if (!neg) return m[63] ? S_MAX : m;
        if (m[63]) return S_MIN;
        return -m;
    endfunction

    function automatic logic signed [63:0] add_s(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S_MIN : S_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sub_s(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? S_MIN : S_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] scaled(logic signed [63:0] v, int k);
        logic signed [127:0] p;
        p = $signed({{64{v[63]}}, v}) * k;
        if (p > $signed({{64{1'b0}}, S_MAX})) return S_MAX;
        if (p < $signed({{64{1'b1}}, S_MIN})) return S_MIN;
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
        logic [127:0] p;
        p = {64'd0, mg(a)} * {64'd0, mg(b)};
        if (p[127:96] != 0) return fm(a[63] ^ b[63], '1);
        return fm(a[63] ^ b[63], p[95:32]);
    endfunction

    function automatic logic signed [63:0] fx_div(logic signed [63:0] a, logic signed [63:0] b);
        logic [127:0] q;
        if (b == 0) return 0;
        q = {mg(a), 32'd0} / {64'd0, mg(b)};
        if (q[127:64] != 0) return fm(a[63] ^ b[63], '1);
        return fm(a[63] ^ b[63], q[63:0]);
    endfunction

    function automatic logic [31:0] whole32(logic signed [63:0] v);
        logic [63:0] m;
        m = mg(v) >> 32;
        if (v[63]) m = -m;
        return m[31:0];
    endfunction

    function automatic logic signed [63:0] of32(logic [31:0] w);
        return scaled($signed({{32{w[31]}}, w}), 1) <<< 32;
    endfunction

    function automatic logic signed [63:0] apply_op(logic [3:0] op, logic signed [63:0] a,
                                                    logic signed [63:0] e);
        case (op)
            kc_pkg::OP_ADD: return add_s(a, e);
            kc_pkg::OP_SUB: return sub_s(a, e);
            kc_pkg::OP_MUL: return fx_mul(a, e);
            kc_pkg::OP_DIV: return fx_div(a, e);
            kc_pkg::OP_AND: return of32(whole32(a) & whole32(e));
            kc_pkg::OP_OR:  return of32(whole32(a) | whole32(e));
            kc_pkg::OP_XOR: return of32(whole32(a) ^ whole32(e));
            kc_pkg::OP_NOT: return of32(~whole32(a));
            default: return a;
        endcase
    endfunction

    task automatic push_undo(logic [63:0] a, logic [63:0] e);
        if (u_cnt >= kc_pkg::HISTORY_DEPTH) begin
            for (int i = 0; i < kc_pkg::HISTORY_DEPTH - 1; i++) begin
                u_acc[i] = u_acc[i+1];
                u_ent[i] = u_ent[i+1];
            end
            u_cnt = kc_pkg::HISTORY_DEPTH - 1;
        end
        u_acc[u_cnt] = a;
        u_ent[u_cnt] = e;
        u_cnt++;
    endtask

    task automatic push_redo(logic [63:0] a, logic [63:0] e);
        if (r_cnt >= kc_pkg::HISTORY_DEPTH) begin
            for (int i = 0; i < kc_pkg::HISTORY_DEPTH - 1; i++) begin
                r_acc[i] = r_acc[i+1];
                r_ent[i] = r_ent[i+1];
            end
            r_cnt = kc_pkg::HISTORY_DEPTH - 1;
        end
        r_acc[r_cnt] = a;
        r_ent[r_cnt] = e;
        r_cnt++;
    endtask

    task automatic predict_key(t_key k);
        t_disp d;
        logic [63:0] div;
        logic signed [63:0] dig;
        if (!k.cmd) begin
            if (k.code > kc_pkg::KEY_POINT) return;
            push_undo(c_acc, c_ent);
            if (k.code == kc_pkg::KEY_POINT) begin
                if (c_pnt > 0) return;
                c_pnt = 1;
            end else begin
                dig = {27'd0, k.code, 32'd0};
                if (c_pnt > 0 && c_pnt < kc_pkg::POINT_MAX) c_pnt++;
                if (c_pnt > 0) begin
                    div = 1;
                    for (int i = 1; i < c_pnt; i++) div = div * (c_hex ? 16 : 10);
                    c_ent = add_s(c_ent, $signed(dig / div));
                end else if (c_ent != 0) begin
                    c_ent = add_s(scaled(c_ent, c_hex ? 16 : 10), dig);
                end else begin
                    c_ent = dig;
                end
            end
            d = '{1'b0, 64'd0, c_ent, 1'b0, c_pnt, 4'd0};
            disp_q.push_back(d);
            return;
        end
        if (k.code > kc_pkg::KEY_RADIX) return;
        d.shown = 0;
        case (k.code)
            kc_pkg::KEY_CLR_ENTRY: begin
                c_ent = 0;
                c_pnt = 0;
            end
            kc_pkg::KEY_CLR_ALL: begin
                c_acc = 0; c_ent = 0; c_pnt = 0; c_hex = 0; c_pend = kc_pkg::OP_ADD;
            end
            kc_pkg::KEY_UNDO: begin
                push_redo(c_acc, c_ent);
                if (u_cnt > 0) begin
                    u_cnt--;
                    c_acc = u_acc[u_cnt];
                    c_ent = u_ent[u_cnt];
                end
            end
            kc_pkg::KEY_REDO: begin
                push_undo(c_acc, c_ent);
                if (r_cnt > 0) begin
                    r_cnt--;
                    c_acc = r_acc[r_cnt];
                    c_ent = r_ent[r_cnt];
                end
            end
            kc_pkg::KEY_RADIX: c_hex = ~c_hex;
            default: begin
                push_undo(c_acc, c_ent);
                if (c_pend != kc_pkg::OP_NONE) begin
                    c_acc = apply_op(c_pend, c_acc, c_ent);
                    c_ent = 0;
                    c_pnt = 0;
                end
                c_pend = k.code[3:0];
                d.shown = k.code[3:0];
            end
        endcase
        d.full = 1'b1;
        d.acc = c_acc;
        d.ent = c_ent;
        d.hex = c_hex;
        d.pnt = c_pnt;
        disp_q.push_back(d);
    endtask

    // Driver: one key request at a time, idle bursts between requests.
    int s_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && !s_taken) begin
                // Hold the current request until it is accepted.
            end else if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (key_q.size() > 0) begin
                i_s_tvalid <= 1'b1;
                {i_s_tuser, i_s_tdata} <= {key_q[0].cmd, 3'd0, key_q[0].code};
                key_q.pop_front();
                if (!calm && $urandom_range(0, 3) == 0) s_gap <= $urandom_range(1, 18);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        s_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready)
            predict_key('{i_s_tuser, i_s_tdata[4:0]});
    end

    // Result side backpressure in bursts.
    int m_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_m_tready <= i_rst_n;
        end else if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0) m_gap <= $urandom_range(1, 18);
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_disp e;
        cycles <= cycles + 1;
        calm <= key_q.size() < 100;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (disp_q.size() == 0) begin
                $error("result with no request pending");
                failed = 1;
            end else begin
                e = disp_q.pop_front();
                if (o_m_tuser !== e.full) begin
                    $error("full_update exp %0h got %0h", e.full, o_m_tuser); failed = 1;
                end
                if (o_m_tdata[63:0] !== e.acc) begin
                    $error("acc_value exp %0h got %0h", e.acc, o_m_tdata[63:0]); failed = 1;
                end
                if (o_m_tdata[127:64] !== e.ent) begin
                    $error("entry_value exp %0h got %0h", e.ent, o_m_tdata[127:64]);
                    failed = 1;
                end
                if (o_m_tdata[128] !== e.hex) begin
                    $error("hex_shown exp %0h got %0h", e.hex, o_m_tdata[128]); failed = 1;
                end
                if (o_m_tdata[132:129] !== e.pnt) begin
                    $error("point_shown exp %0h got %0h", e.pnt, o_m_tdata[132:129]);
                    failed = 1;
                end
                if (o_m_tdata[136:133] !== e.shown) begin
                    $error("shown_operator exp %0h got %0h", e.shown, o_m_tdata[136:133]);
                    failed = 1;
                end
            end
        end
    end

    task automatic add_key(bit c, int code);
        t_key k;
        k.cmd = c;
        k.code = code[4:0];
        key_q.push_back(k);
    endtask

    // Well-formed run: a number, maybe a fraction, then an operator.
    task automatic add_number_run();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) add_key(0, $urandom_range(0, 15));
        if ($urandom_range(0, 2) == 0) begin
            add_key(0, kc_pkg::KEY_POINT);
            n = $urandom_range(1, 17);
            for (int i = 0; i < n; i++) add_key(0, $urandom_range(0, 15));
        end
        add_key(1, $urandom_range(0, 8));
    endtask

    initial begin
        c_acc = 0; c_ent = 0; c_pnt = 0; c_hex = 0; c_pend = kc_pkg::OP_ADD;
        u_cnt = 0; r_cnt = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: extremes, every operator, ignored codes, second point, empty undo/redo.
        add_key(1, kc_pkg::KEY_UNDO);
        add_key(1, kc_pkg::KEY_REDO);
        for (int i = 0; i < 12; i++) add_key(0, 15);
        add_key(0, kc_pkg::KEY_POINT);
        add_key(0, kc_pkg::KEY_POINT);
        add_key(0, 9);
        add_key(0, 31);
        add_key(1, 31);
        add_key(1, 14);
        for (int op = 1; op <= 8; op++) add_key(1, op);
        add_key(0, 0);
        add_key(1, kc_pkg::OP_DIV);
        add_key(1, kc_pkg::KEY_NOP);
        add_key(1, kc_pkg::KEY_RADIX);
        for (int i = 0; i < 20; i++) add_key(0, $urandom_range(0, 15));
        add_key(1, kc_pkg::OP_MUL);
        add_key(1, kc_pkg::KEY_CLR_ENTRY);
        add_key(1, kc_pkg::KEY_CLR_ALL);

        while (key_q.size() < 950) begin
            case ($urandom_range(0, 9))
                0: add_key($urandom_range(0, 1), $urandom_range(0, 31));
                1: add_key(1, $urandom_range(kc_pkg::KEY_CLR_ENTRY, kc_pkg::KEY_RADIX));
                2: for (int i = 0; i < $urandom_range(1, 20); i++) add_key(1, kc_pkg::KEY_UNDO);
                3: for (int i = 0; i < $urandom_range(1, 20); i++) add_key(1, kc_pkg::KEY_REDO);
                default: add_number_run();
            endcase
        end

        while ((key_q.size() > 0 || i_s_tvalid || disp_q.size() > 0) && cycles < LIMIT)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (cycles >= LIMIT) begin
            $display("Some tests failed");
        end else if (!failed && disp_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
